>>> rtl/twrtc_pkg.sv
// ----------------------------------------------------------------------------
// twrtc_pkg
// Shared types and timing constants of the three-wire rtc register master.
// ----------------------------------------------------------------------------
package twrtc_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_PRE    = 4'd1,
        PH_SETUP  = 4'd2,
        PH_SH_LO  = 4'd3,
        PH_SH_HI  = 4'd4,
        PH_POST   = 4'd5,
        PH_R_REL  = 4'd6,
        PH_R_GAP  = 4'd7,
        PH_R_HI   = 4'd8,
        PH_R_LO   = 4'd9,
        PH_R_TAIL = 4'd10
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       io_in;
    } t_item;

    typedef struct packed {
        logic       serial_clock;
        logic       chip_enable;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_result;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;
    localparam logic [7:0] WR_PRE_TICKS      = 8'd1;
    localparam logic [7:0] RD_PRE_TICKS      = 8'd3;
    localparam logic [7:0] WR_SETUP_TICKS    = 8'd2;
    localparam logic [7:0] RD_SETUP_TICKS    = 8'd3;
    localparam logic [7:0] POST_TICKS        = 8'd2;
    localparam logic [7:0] RD_REL_TICKS      = 8'd2;
    localparam logic [7:0] RD_GAP_TICKS      = 8'd2;
    localparam logic [7:0] RD_HI_TICKS       = 8'd4;
    localparam logic [7:0] RD_LO_TICKS       = 8'd14;
    localparam logic [3:0] WR_LAST_BIT       = 4'd15;
    localparam logic [3:0] RD_LAST_BIT       = 4'd7;

endpackage

>>> rtl/twrtc_in_reg.sv
// ----------------------------------------------------------------------------
// twrtc_in_reg
// Input register: holds one accepted beat until the core takes it.
// ----------------------------------------------------------------------------
module twrtc_in_reg
    import twrtc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/twrtc_core.sv
// ----------------------------------------------------------------------------
// twrtc_core
// Pin sequencer: advances the bus state by one tick per beat and forms the
// pin levels shown for that tick.
// ----------------------------------------------------------------------------
module twrtc_core
    import twrtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_step,
    input  t_item      i_item,
    output t_result    o_result
);

    logic [7:0]  r_half;
    t_phase      r_phase,     n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_tick,      n_tick;
    logic [15:0] r_out_shift, n_out_shift;
    logic [7:0]  r_in_shift,  n_in_shift;
    logic        r_is_read,   n_is_read;
    logic        r_sclk,      n_sclk;
    logic        r_ce,        n_ce;
    logic        r_io,        n_io;
    logic        r_drive,     n_drive;
    logic        n_done;
    logic [7:0]  w_half;

    assign w_half = (r_half == 8'd0) ? 8'd1 : r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_tick      = r_tick;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_is_read   = r_is_read;
        n_sclk      = r_sclk;
        n_ce        = r_ce;
        n_io        = r_io;
        n_drive     = r_drive;
        n_done      = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_item.opcode == OP_WRITE || i_item.opcode == OP_READ) begin
                n_is_read = (i_item.opcode == OP_READ);
                if (i_item.opcode == OP_READ) begin
                    n_out_shift = {8'd0, i_item.register_address};
                    n_bit_count = RD_LAST_BIT;
                    n_in_shift  = 8'd0;
                    n_tick      = RD_PRE_TICKS;
                end else begin
                    n_out_shift = {i_item.write_data, i_item.register_address};
                    n_bit_count = WR_LAST_BIT;
                    n_tick      = WR_PRE_TICKS;
                end
                n_ce    = 1'b0;
                n_sclk  = 1'b0;
                n_drive = 1'b1;
                n_phase = PH_PRE;
            end
        end else if (r_tick > 8'd1) begin
            n_tick = r_tick - 8'd1;
        end else begin
            unique case (r_phase)
                PH_PRE: begin
                    n_ce    = 1'b1;
                    n_phase = PH_SETUP;
                    n_tick  = r_is_read ? RD_SETUP_TICKS : WR_SETUP_TICKS;
                end
                PH_SETUP: begin
                    n_sclk      = 1'b0;
                    n_io        = r_out_shift[0];
                    n_out_shift = {1'b0, r_out_shift[15:1]};
                    n_phase     = PH_SH_LO;
                    n_tick      = w_half;
                end
                PH_SH_LO: begin
                    n_sclk  = 1'b1;
                    n_phase = PH_SH_HI;
                    n_tick  = w_half;
                end
                PH_SH_HI: begin
                    if (r_bit_count != 4'd0) begin
                        n_bit_count = r_bit_count - 4'd1;
                        n_sclk      = 1'b0;
                        n_io        = r_out_shift[0];
                        n_out_shift = {1'b0, r_out_shift[15:1]};
                        n_phase     = PH_SH_LO;
                        n_tick      = w_half;
                    end else if (r_is_read) begin
                        n_drive = 1'b0;
                        n_phase = PH_R_REL;
                        n_tick  = RD_REL_TICKS;
                    end else begin
                        n_ce    = 1'b0;
                        n_sclk  = 1'b0;
                        n_phase = PH_POST;
                        n_tick  = POST_TICKS;
                    end
                end
                PH_R_REL: begin
                    n_bit_count = RD_LAST_BIT;
                    n_phase     = PH_R_GAP;
                    n_tick      = RD_GAP_TICKS;
                end
                PH_R_GAP: begin
                    n_in_shift = {1'b0, r_in_shift[7:1]};
                    n_sclk     = 1'b1;
                    n_phase    = PH_R_HI;
                    n_tick     = RD_HI_TICKS;
                end
                PH_R_HI: begin
                    n_sclk  = 1'b0;
                    n_phase = PH_R_LO;
                    n_tick  = RD_LO_TICKS;
                end
                PH_R_LO: begin
                    n_in_shift = {r_in_shift[7] | i_item.io_in, r_in_shift[6:0]};
                    if (r_bit_count != 4'd0) begin
                        n_bit_count = r_bit_count - 4'd1;
                        n_phase     = PH_R_GAP;
                    end else begin
                        n_phase = PH_R_TAIL;
                    end
                    n_tick = RD_GAP_TICKS;
                end
                PH_R_TAIL: begin
                    n_ce    = 1'b0;
                    n_sclk  = 1'b0;
                    n_io    = 1'b0;
                    n_drive = 1'b1;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_POST: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // pin levels after this tick
    always_comb begin
        o_result.serial_clock = n_sclk;
        o_result.chip_enable  = n_ce;
        o_result.io_out       = n_io;
        o_result.io_drive     = n_drive;
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.done_res     = n_done;
        o_result.read_data    = n_in_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= 4'd0;
            r_tick      <= 8'd0;
            r_out_shift <= 16'd0;
            r_in_shift  <= 8'd0;
            r_is_read   <= 1'b0;
            r_sclk      <= 1'b0;
            r_ce        <= 1'b0;
            r_io        <= 1'b0;
            r_drive     <= 1'b1;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_tick      <= n_tick;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_is_read   <= n_is_read;
            r_sclk      <= n_sclk;
            r_ce        <= n_ce;
            r_io        <= n_io;
            r_drive     <= n_drive;
        end
    end

endmodule

>>> rtl/twrtc_out_reg.sv
// ----------------------------------------------------------------------------
// twrtc_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module twrtc_out_reg
    import twrtc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_ready,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> rtl/three_wire_rtc_register_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_register_master
// Pin-level master for a three-wire rtc register bus, one tick per beat.
// ----------------------------------------------------------------------------
// Each input beat is one timing tick: it may start a register write or read
// and carries the sampled IO level; each beat gives exactly one result beat
// with the SCLK, CE and IO pin levels after that tick. One beat is taken
// every clock cycle unless the result is stalled; the input and result
// registers sit around the tick sequencer. Commands seen during a transfer
// or on its finishing tick are ignored. The half-period register is written
// over its own port; the user must write it only while idle (not enforced).
module three_wire_rtc_register_master
    import twrtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_register_address,
    input  logic [7:0] i_write_data,
    input  logic       i_io_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_serial_clock,
    output logic       o_chip_enable,
    output logic       o_io_out,
    output logic       o_io_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_out_ready;
    logic    w_step;
    t_result w_core_result;
    t_result w_result;

    assign w_in_item.opcode           = i_opcode;
    assign w_in_item.register_address = i_register_address;
    assign w_in_item.write_data       = i_write_data;
    assign w_in_item.io_in            = i_io_in;

    assign w_step      = w_item_valid && w_out_ready;
    assign o_cfg_ready = 1'b1;

    twrtc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_take  (w_step),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    twrtc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_step),
        .i_item     (w_item),
        .o_result   (w_core_result)
    );

    twrtc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_result (w_core_result),
        .o_ready  (w_out_ready),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (w_result)
    );

    assign o_serial_clock = w_result.serial_clock;
    assign o_chip_enable  = w_result.chip_enable;
    assign o_io_out       = w_result.io_out;
    assign o_io_drive     = w_result.io_drive;
    assign o_busy_res     = w_result.busy_res;
    assign o_done_res     = w_result.done_res;
    assign o_read_data    = w_result.read_data;

endmodule

>>> rtl/twrtc_checker.sv
// ----------------------------------------------------------------------------
// twrtc_checker
// Port-level checks of the three-wire rtc register master, bound to the top.
// ----------------------------------------------------------------------------
module twrtc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_opcode,
    input logic [7:0] i_register_address,
    input logic [7:0] i_write_data,
    input logic       i_io_in,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_serial_clock,
    input logic       o_chip_enable,
    input logic       o_io_out,
    input logic       o_io_drive,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_read_data,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [7:0] i_cfg_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data)
            && $stable(o_done_res) && $stable(o_busy_res))
        else $error("result beat changed while stalled");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done shown while still busy");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> !o_chip_enable && !o_serial_clock && o_io_drive)
        else $error("bus pins not parked while idle");

    a_release_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_io_drive |-> o_busy_res && o_chip_enable)
        else $error("io released outside a framed read");

endmodule

bind three_wire_rtc_register_master twrtc_checker u_twrtc_checker (.*);
